>>> rtl/tgd_pkg.sv
// Package for the torus grid distance block: widths, register map and word types.
// It depends on nothing. The top level and the square root pipeline use it.
`default_nettype none
package tgd_pkg;

  localparam int PosBits   = 24;
  localparam int RowBits   = 12;
  localparam int SqBits    = 2 * RowBits;
  localparam int SumBits   = SqBits + 1;
  localparam int RadShift  = 34;
  localparam int RootBits  = (SumBits + RadShift + 1) / 2;
  localparam int RadBits   = 2 * RootBits;
  localparam int AbsBits   = 20;
  localparam int AbsShift  = 9;
  localparam int RelBits   = 17;
  localparam int AddrBits  = 2;
  localparam int DataBits  = 32;

  localparam logic [RelBits-1:0]  RelOne        = RelBits'(65536);
  localparam logic [AddrBits-1:0] AddrRowLength = AddrBits'(0);

  typedef struct packed {
    logic [PosBits-1:0] first_position;
    logic [PosBits-1:0] second_position;
  } in_word_t;

  typedef struct packed {
    logic [AbsBits-1:0] abs_distance;
    logic [RelBits-1:0] rel_distance;
  } out_word_t;

endpackage
`default_nettype wire

>>> rtl/tgd_isqrt.sv
// Pipelined integer square root of the squared distance scaled by 2^34, one root bit
// per stage. It depends on tgd_pkg and carries the saturation flag alongside.
`default_nettype none
module tgd_isqrt (
  input  wire logic                         clk_i,
  input  wire logic [tgd_pkg::SumBits-1:0]  s_i,
  input  wire logic                         sat_i,
  output logic      [tgd_pkg::RootBits-1:0] root_o,
  output logic                              sat_o
);

  localparam int RootBits = tgd_pkg::RootBits;
  localparam int RadBits  = tgd_pkg::RadBits;

  logic [RadBits-1:0]  rad_q  [RootBits+1];
  logic [RootBits:0]   rem_q  [RootBits+1];
  logic [RootBits-1:0] root_q [RootBits+1];
  logic                sat_q  [RootBits+1];

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= RadBits'({s_i, {tgd_pkg::RadShift{1'b0}}});
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    sat_q[0]  <= sat_i;
  end

  for (genvar k = 0; k < RootBits; k++) begin : g_step
    logic [RootBits+2:0] cur;
    logic [RootBits+2:0] trial;

    always_comb begin
      cur   = {rem_q[k], rad_q[k][RadBits-1 -: 2]};
      trial = (RootBits+3)'({root_q[k], 2'b01});
    end

    always_ff @(posedge clk_i) begin
      rad_q[k+1] <= rad_q[k] << 2;
      sat_q[k+1] <= sat_q[k];
      if (cur >= trial) begin
        rem_q[k+1]  <= (RootBits+1)'(cur - trial);
        root_q[k+1] <= {root_q[k][RootBits-2:0], 1'b1};
      end else begin
        rem_q[k+1]  <= cur[RootBits:0];
        root_q[k+1] <= {root_q[k][RootBits-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_q[RootBits];
  assign sat_o  = sat_q[RootBits];

endmodule
`default_nettype wire

>>> rtl/torus_grid_distance.sv
// Top level of the torus grid distance block: register port, division and wrap stages,
// and the final division for the relative distance. It depends on tgd_pkg and tgd_isqrt.
//
//   channel   | handshake                       | word
//   ----------+---------------------------------+-------------------------------
//   input     | start_i high while busy_o low    | in_word_i (two positions)
//   result    | valid_o high for one cycle       | out_word_o (abs, rel distance)
//   register  | psel, penable, pwrite, pready    | row_length at byte address 0
//
// A new word is taken in every cycle; busy_o stays low.
// Each result passes through the bit-serial dividers (24 plus 24 steps), the 30-step
// square root and the 17-step final division.
// Reset clears the valid bits and sets the row length to one.
`default_nettype none
module torus_grid_distance (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire tgd_pkg::in_word_t                   in_word_i,
  output logic                                     valid_o,
  output tgd_pkg::out_word_t                       out_word_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tgd_pkg::AddrBits-1:0]        paddr,
  input  wire logic [tgd_pkg::DataBits-1:0]        pwdata,
  output logic      [tgd_pkg::DataBits-1:0]        prdata,
  output logic                                     pready
);

  localparam int PosBits  = tgd_pkg::PosBits;
  localparam int RowBits  = tgd_pkg::RowBits;
  localparam int SqBits   = tgd_pkg::SqBits;
  localparam int SumBits  = tgd_pkg::SumBits;
  localparam int RootBits = tgd_pkg::RootBits;
  localparam int RelBits  = tgd_pkg::RelBits;
  localparam int AbsBits  = tgd_pkg::AbsBits;
  localparam int Lat      = 1 + PosBits + 1 + SqBits + 5 + 1 + RootBits + 1 + RelBits;

  logic [RowBits-1:0] row_q;
  logic [RowBits-1:0] len_q;
  logic [SqBits-1:0]  lsq_q;
  logic [RowBits-1:0] wr_row;
  logic [RowBits-1:0] wr_len;
  logic               wr_en;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == tgd_pkg::AddrRowLength);
  assign wr_row = pwdata[RowBits-1:0];
  assign wr_len = (wr_row == '0) ? RowBits'(1) : wr_row;
  assign prdata = (paddr == tgd_pkg::AddrRowLength) ? tgd_pkg::DataBits'(row_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= RowBits'(1);
      len_q <= RowBits'(1);
      lsq_q <= SqBits'(1);
    end else if (wr_en) begin
      row_q <= wr_row;
      len_q <= wr_len;
      lsq_q <= wr_len * wr_len;
    end
  end

  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i && !busy_o};
    end
  end

  assign valid_o = vld_q[Lat-1];

  // First division: each position modulo the square of the row length.
  logic [PosBits-1:0] d1_pos_q [PosBits+1][2];
  logic [SqBits-1:0]  d1_rem_q [PosBits+1][2];

  always_ff @(posedge clk_i) begin
    d1_pos_q[0][0] <= in_word_i.first_position;
    d1_pos_q[0][1] <= in_word_i.second_position;
    d1_rem_q[0][0] <= '0;
    d1_rem_q[0][1] <= '0;
  end

  for (genvar k = 0; k < PosBits; k++) begin : g_div1
    logic [SqBits:0] trial [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {d1_rem_q[k][l], d1_pos_q[k][l][PosBits-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 2; l++) begin
        d1_pos_q[k+1][l] <= d1_pos_q[k][l] << 1;
        if (trial[l] >= {1'b0, lsq_q}) begin
          d1_rem_q[k+1][l] <= SqBits'(trial[l] - {1'b0, lsq_q});
        end else begin
          d1_rem_q[k+1][l] <= trial[l][SqBits-1:0];
        end
      end
    end
  end

  // Second division: the remainder by the row length gives column and row on the torus.
  logic [SqBits-1:0]  d2_m_q   [SqBits+1][2];
  logic [RowBits-1:0] d2_rem_q [SqBits+1][2];
  logic [RowBits-1:0] d2_quo_q [SqBits+1][2];

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      d2_m_q[0][l]   <= d1_rem_q[PosBits][l];
      d2_rem_q[0][l] <= '0;
      d2_quo_q[0][l] <= '0;
    end
  end

  for (genvar k = 0; k < SqBits; k++) begin : g_div2
    logic [RowBits:0] trial [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {d2_rem_q[k][l], d2_m_q[k][l][SqBits-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 2; l++) begin
        d2_m_q[k+1][l] <= d2_m_q[k][l] << 1;
        if (trial[l] >= {1'b0, len_q}) begin
          d2_rem_q[k+1][l] <= RowBits'(trial[l] - {1'b0, len_q});
          d2_quo_q[k+1][l] <= {d2_quo_q[k][l][RowBits-2:0], 1'b1};
        end else begin
          d2_rem_q[k+1][l] <= trial[l][RowBits-1:0];
          d2_quo_q[k+1][l] <= {d2_quo_q[k][l][RowBits-2:0], 1'b0};
        end
      end
    end
  end

  // Axis differences modulo the row length, then the shorter way round.
  logic [RowBits:0]   dx_diff;
  logic [RowBits:0]   dy_diff;
  logic [RowBits-1:0] dx_q;
  logic [RowBits-1:0] dy_q;
  logic [RowBits-1:0] ex;
  logic [RowBits-1:0] ey;
  logic [RowBits-1:0] wx_q;
  logic [RowBits-1:0] wy_q;
  logic [SqBits-1:0]  sqx_q;
  logic [SqBits-1:0]  sqy_q;
  logic [SumBits-1:0] s_q;
  logic [SumBits-1:0] s2_q;
  logic               sat_q;

  assign dx_diff = {1'b0, d2_rem_q[SqBits][0]} - {1'b0, d2_rem_q[SqBits][1]};
  assign dy_diff = {1'b0, d2_quo_q[SqBits][0]} - {1'b0, d2_quo_q[SqBits][1]};
  assign ex      = len_q - dx_q;
  assign ey      = len_q - dy_q;

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_diff[RowBits] ? RowBits'(dx_diff + {1'b0, len_q}) : dx_diff[RowBits-1:0];
    dy_q  <= dy_diff[RowBits] ? RowBits'(dy_diff + {1'b0, len_q}) : dy_diff[RowBits-1:0];
    wx_q  <= ((dx_q != '0) && (ex < dx_q)) ? ex : dx_q;
    wy_q  <= ((dy_q != '0) && (ey < dy_q)) ? ey : dy_q;
    sqx_q <= wx_q * wx_q;
    sqy_q <= wy_q * wy_q;
    s_q   <= {1'b0, sqx_q} + {1'b0, sqy_q};
    s2_q  <= s_q;
    sat_q <= {s_q, 2'b00} >= (SumBits+2)'(lsq_q);
  end

  logic [RootBits-1:0] root;
  logic                root_sat;

  tgd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .s_i    (s2_q),
    .sat_i  (sat_q),
    .root_o (root),
    .sat_o  (root_sat)
  );

  // Final division of the scaled root by the row length.
  logic [RowBits-1:0] rd_rem_q [RelBits+1];
  logic [RelBits-1:0] rd_lo_q  [RelBits+1];
  logic [RelBits-1:0] rd_quo_q [RelBits+1];
  logic [AbsBits-1:0] rd_abs_q [RelBits+1];
  logic               rd_sat_q [RelBits+1];

  always_ff @(posedge clk_i) begin
    rd_rem_q[0] <= RowBits'(root >> RelBits);
    rd_lo_q[0]  <= root[RelBits-1:0];
    rd_quo_q[0] <= '0;
    rd_abs_q[0] <= root[tgd_pkg::AbsShift +: AbsBits];
    rd_sat_q[0] <= root_sat;
  end

  for (genvar k = 0; k < RelBits; k++) begin : g_div3
    logic [RowBits:0] trial;

    assign trial = {rd_rem_q[k], rd_lo_q[k][RelBits-1]};

    always_ff @(posedge clk_i) begin
      rd_lo_q[k+1]  <= rd_lo_q[k] << 1;
      rd_abs_q[k+1] <= rd_abs_q[k];
      rd_sat_q[k+1] <= rd_sat_q[k];
      if (trial >= {1'b0, len_q}) begin
        rd_rem_q[k+1] <= RowBits'(trial - {1'b0, len_q});
        rd_quo_q[k+1] <= {rd_quo_q[k][RelBits-2:0], 1'b1};
      end else begin
        rd_rem_q[k+1] <= trial[RowBits-1:0];
        rd_quo_q[k+1] <= {rd_quo_q[k][RelBits-2:0], 1'b0};
      end
    end
  end

  assign out_word_o.abs_distance = rd_abs_q[RelBits];
  assign out_word_o.rel_distance = rd_sat_q[RelBits] ? tgd_pkg::RelOne : rd_quo_q[RelBits];

endmodule
`default_nettype wire
